// File: src/gzip_member_deframer_defines.svh
// Assertion helpers shared by the deframer modules.
`ifndef GZIP_MEMBER_DEFRAMER_DEFINES_SVH
`define GZIP_MEMBER_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GMD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define GMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// File: src/gmd_pkg.sv
package gmd_pkg;

  localparam int TRAILER_BYTES = 8;
  localparam int FILL_W        = $clog2(TRAILER_BYTES + 1);
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ID1_BYTE = 8'h1F;
  localparam logic [7:0] ID2_BYTE = 8'h8B;
  localparam logic [7:0] CM_DEFLATE = 8'd8;

  // bit positions in the kept flag nibble (FLG bits 1..4)
  localparam int FL_HCRC    = 0;
  localparam int FL_EXTRA   = 1;
  localparam int FL_NAME    = 2;
  localparam int FL_COMMENT = 3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_TRAILER = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MAGIC    = 2'd0,
    ERR_METHOD   = 2'd1,
    ERR_RESERVED = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    PH_ID1, PH_ID2, PH_CM, PH_FLG, PH_MTIME, PH_XFL, PH_OS,
    PH_XLEN_LO, PH_XLEN_HI, PH_XDATA, PH_FNAME, PH_FCOMMENT, PH_HCRC,
    PH_PAYLOAD, PH_HALT
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [31:0] crc;
    logic [31:0] isize;
    err_e        err;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: src/gmd_parser.sv
`include "gzip_member_deframer_defines.svh"

module gmd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          is_final_i,
  input  logic          room_i,
  output gmd_pkg::push_t push_o
);
  import gmd_pkg::*;

  logic                               in_valid_q, in_valid_d;
  logic [7:0]                         byte_q;
  logic                               fin_q;
  phase_e                             phase_q, phase_d;
  logic [3:0]                         pend_q, pend_d;
  logic [15:0]                        fc_q, fc_d;
  logic [FILL_W-1:0]                  fill_q, fill_d;
  logic [TRAILER_BYTES-1:0][7:0]      tb_q, tb_d;

  logic  accept, proc, nf, err_hit, pay_hit, has_tail;
  err_e  err_c;
  res_t  pay_r, tres;

  assign proc       = in_valid_q & room_i;
  assign in_stall_o = in_valid_q & ~proc;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_valid_d = accept | (in_valid_q & ~proc);

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    fc_d     = fc_q;
    fill_d   = fill_q;
    tb_d     = tb_q;
    nf       = 1'b0;
    err_hit  = 1'b0;
    err_c    = ERR_MAGIC;
    pay_hit  = 1'b0;
    has_tail = 1'b0;
    pay_r    = '0;
    tres     = '0;
    push_o   = '0;

    if (proc && phase_q != PH_HALT) begin
      case (phase_q)
        PH_ID1: begin
          if (byte_q != ID1_BYTE) begin
            err_hit = 1'b1;
          end else begin
            phase_d = PH_ID2;
          end
        end
        PH_ID2: begin
          if (byte_q != ID2_BYTE) begin
            err_hit = 1'b1;
          end else begin
            phase_d = PH_CM;
          end
        end
        PH_CM: begin
          if (byte_q != CM_DEFLATE) begin
            err_hit = 1'b1;
            err_c   = ERR_METHOD;
          end else begin
            phase_d = PH_FLG;
          end
        end
        PH_FLG: begin
          if (byte_q[7:5] != 3'b000) begin
            err_hit = 1'b1;
            err_c   = ERR_RESERVED;
          end else begin
            pend_d  = byte_q[4:1];
            fc_d    = 16'd4;
            phase_d = PH_MTIME;
          end
        end
        PH_MTIME: begin
          fc_d = fc_q - 16'd1;
          if (fc_d == 16'd0) phase_d = PH_XFL;
        end
        PH_XFL:     phase_d = PH_OS;
        PH_OS:      nf = 1'b1;
        PH_XLEN_LO: begin
          fc_d    = {8'd0, byte_q};
          phase_d = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          fc_d = {byte_q, fc_q[7:0]};
          if (fc_d == 16'd0) begin
            nf = 1'b1;
          end else begin
            phase_d = PH_XDATA;
          end
        end
        PH_XDATA, PH_HCRC: begin
          fc_d = fc_q - 16'd1;
          if (fc_d == 16'd0) nf = 1'b1;
        end
        PH_FNAME, PH_FCOMMENT: begin
          if (byte_q == 8'd0) nf = 1'b1;
        end
        PH_PAYLOAD: begin
          tb_d = {byte_q, tb_q[TRAILER_BYTES-1:1]};
          if (fill_q < FILL_W'(TRAILER_BYTES)) begin
            fill_d = fill_q + FILL_W'(1);
          end else begin
            pay_hit = 1'b1;
          end
        end
        default: phase_d = PH_HALT;
      endcase

      if (nf) begin
        if (pend_q[FL_EXTRA]) begin
          pend_d[FL_EXTRA] = 1'b0;
          phase_d          = PH_XLEN_LO;
        end else if (pend_q[FL_NAME]) begin
          pend_d[FL_NAME] = 1'b0;
          phase_d         = PH_FNAME;
        end else if (pend_q[FL_COMMENT]) begin
          pend_d[FL_COMMENT] = 1'b0;
          phase_d            = PH_FCOMMENT;
        end else if (pend_q[FL_HCRC]) begin
          pend_d[FL_HCRC] = 1'b0;
          fc_d            = 16'd2;
          phase_d         = PH_HCRC;
        end else begin
          pend_d  = '0;
          phase_d = PH_PAYLOAD;
        end
      end

      tres.last = 1'b1;
      if (err_hit) begin
        has_tail  = 1'b1;
        tres.kind = KIND_ERROR;
        tres.err  = err_c;
        phase_d   = PH_HALT;
      end else if (fin_q) begin
        has_tail = 1'b1;
        if (phase_d == PH_PAYLOAD && fill_d == FILL_W'(TRAILER_BYTES)) begin
          tres.kind  = KIND_TRAILER;
          tres.crc   = tb_d[3:0];
          tres.isize = tb_d[TRAILER_BYTES-1:4];
          phase_d    = PH_ID1;
          pend_d     = '0;
          fc_d       = '0;
          fill_d     = '0;
        end else begin
          tres.kind = KIND_ERROR;
          tres.err  = ERR_TRUNC;
          phase_d   = PH_HALT;
        end
      end

      pay_r.kind    = KIND_PAYLOAD;
      pay_r.payload = tb_q[0];
      pay_r.last    = ~has_tail;

      if (pay_hit) begin
        push_o.r0 = pay_r;
        push_o.r1 = tres;
        push_o.n  = has_tail ? 2'd2 : 2'd1;
      end else begin
        push_o.r0 = tres;
        push_o.n  = has_tail ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_ID1;
      pend_q     <= '0;
      fc_q       <= '0;
      fill_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      phase_q    <= phase_d;
      pend_q     <= pend_d;
      fc_q       <= fc_d;
      fill_q     <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      fin_q  <= is_final_i;
    end
    tb_q <= tb_d;
  end

  `GMD_ASSERT_NEXT(a_err_halts, proc && err_hit, phase_q == PH_HALT)
  `GMD_ASSERT(a_pair_order, push_o.n == 2'd2, push_o.r0.kind == KIND_PAYLOAD && push_o.r1.last)
  `GMD_ASSERT_NEXT(a_trailer_rearms, proc && has_tail && tres.kind == KIND_TRAILER, phase_q == PH_ID1 && fill_q == '0)

endmodule

// File: src/gmd_out_fifo.sv
`include "gzip_member_deframer_defines.svh"

module gmd_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gmd_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gmd_pkg::res_t  head_o
);
  import gmd_pkg::*;

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rptr_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign room_o      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  always_comb begin
    wptr_d  = wptr_q + FIFO_PTR_W'(push_i.n);
    rptr_d  = rptr_q + FIFO_PTR_W'(pop);
    count_d = count_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wptr_q + FIFO_PTR_W'(1)] <= push_i.r1;
  end

  `GMD_ASSERT(a_no_overflow, push_i.n != 2'd0, room_o)
  `GMD_ASSERT(a_count_bound, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH))
  `GMD_ASSERT_NEXT(a_head_steady, out_valid_o && out_stall_i, out_valid_o && $stable(head_o))

endmodule

// File: src/gzip_member_deframer.sv
// gzip member deframer.
// Input channel: one member byte per beat (in_byte_i, is_final_i marks the
// last byte of a member), handshake in_valid_i / in_stall_o.
// Output channel: one result per beat, handshake out_valid_o / out_stall_i.
// A result is a payload byte, a trailer report (CRC32 and ISIZE) or an error
// report; last_of_run_o flags the final result caused by one input byte.
// Header bytes give no result unless they are in error; the last eight payload bytes are held back
// and come out as the trailer report on the final byte.
// A taken byte is registered, then parsed once the result queue has room;
// its results are written into the queue and offered from its head.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver does not stall; a byte yielding two results costs one
// extra output beat.
// A four-entry result queue decouples the sides; input is stalled when it
// has fewer than two free places, so a stalled receiver backs up to the
// input while the head result holds steady.
// Reset clears the parser to expect a new member and empties the queue.
// After an error the block drops all bytes until reset.
module gzip_member_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        is_final_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] trailer_crc_o,
  output logic [31:0] trailer_isize_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);
  import gmd_pkg::*;

  push_t push;
  res_t  head;
  logic  room;

  gmd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .is_final_i (is_final_i),
    .room_i     (room),
    .push_o     (push)
  );

  gmd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o          = head.kind;
  assign payload_byte_o  = head.payload;
  assign trailer_crc_o   = head.crc;
  assign trailer_isize_o = head.isize;
  assign error_code_o    = head.err;
  assign last_of_run_o   = head.last;

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gmd_pkg::*;

  localparam logic [7:0] FLG_RESERVED = 8'hE0;
  localparam int         SETTLE_CYCLES = 80;

  typedef enum int {
    END_CLEAN, END_BAD_ID1, END_BAD_ID2, END_BAD_CM, END_RESERVED, END_TRUNC_HDR,
    END_SHORT_PAYLOAD
  } ending_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       hold;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_final = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [31:0] trailer_crc;
  logic [31:0] trailer_isize;
  logic [1:0]  error_code;
  logic        last_of_run;

  gzip_member_deframer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .is_final_i     (in_final),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .payload_byte_o (payload_byte),
    .trailer_crc_o  (trailer_crc),
    .trailer_isize_o(trailer_isize),
    .error_code_o   (error_code),
    .last_of_run_o  (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state mirror
  phase_e      hdr_phase = PH_ID1;
  logic [3:0]  opt_left = 4'h0;
  logic [15:0] skip_count = 16'h0000;
  logic [7:0]  held [TRAILER_BYTES];
  int          held_count = 0;

  stim_t member_bytes [$];
  res_t  results_due [$];

  int failures = 0;
  int bytes_planned = 0;
  int bytes_taken = 0;
  int drains = 0;
  int seen_payload = 0;
  int seen_trailer = 0;
  int seen_error = 0;
  int byte_idx = 0;
  int cut_at = -1;
  int in_gap = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;

  function automatic res_t make_res(kind_e k, logic [7:0] p, logic [31:0] c,
                                    logic [31:0] s, err_e e);
    res_t r;
    r.kind    = k;
    r.payload = p;
    r.crc     = c;
    r.isize   = s;
    r.err     = e;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic next_field;
    if (opt_left[FL_EXTRA]) begin
      opt_left[FL_EXTRA] = 1'b0;
      hdr_phase = PH_XLEN_LO;
    end else if (opt_left[FL_NAME]) begin
      opt_left[FL_NAME] = 1'b0;
      hdr_phase = PH_FNAME;
    end else if (opt_left[FL_COMMENT]) begin
      opt_left[FL_COMMENT] = 1'b0;
      hdr_phase = PH_FCOMMENT;
    end else if (opt_left[FL_HCRC]) begin
      opt_left[FL_HCRC] = 1'b0;
      skip_count = 16'd2;
      hdr_phase = PH_HCRC;
    end else begin
      opt_left = 4'h0;
      hdr_phase = PH_PAYLOAD;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic fin);
    res_t outs [2];
    int   n;
    bit   bad;
    err_e code;
    n = 0;
    bad = 1'b0;
    code = ERR_MAGIC;
    if (hdr_phase != PH_HALT) begin
      case (hdr_phase)
        PH_ID1: if (b != ID1_BYTE) bad = 1'b1; else hdr_phase = PH_ID2;
        PH_ID2: if (b != ID2_BYTE) bad = 1'b1; else hdr_phase = PH_CM;
        PH_CM: begin
          if (b != CM_DEFLATE) begin
            bad = 1'b1;
            code = ERR_METHOD;
          end else hdr_phase = PH_FLG;
        end
        PH_FLG: begin
          if ((b & FLG_RESERVED) != 8'h00) begin
            bad = 1'b1;
            code = ERR_RESERVED;
          end else begin
            opt_left = b[4:1];
            skip_count = 16'd4;
            hdr_phase = PH_MTIME;
          end
        end
        PH_MTIME: begin
          skip_count = skip_count - 16'd1;
          if (skip_count == 16'd0) hdr_phase = PH_XFL;
        end
        PH_XFL: hdr_phase = PH_OS;
        PH_OS: next_field();
        PH_XLEN_LO: begin
          skip_count = {8'h00, b};
          hdr_phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_count[15:8] = b;
          if (skip_count == 16'd0) next_field(); else hdr_phase = PH_XDATA;
        end
        PH_XDATA, PH_HCRC: begin
          skip_count = skip_count - 16'd1;
          if (skip_count == 16'd0) next_field();
        end
        PH_FNAME, PH_FCOMMENT: if (b == 8'h00) next_field();
        PH_PAYLOAD: begin
          if (held_count < TRAILER_BYTES) begin
            held[held_count] = b;
            held_count++;
          end else begin
            outs[n] = make_res(KIND_PAYLOAD, held[0], 32'h0, 32'h0, ERR_MAGIC);
            n++;
            for (int i = 0; i < TRAILER_BYTES - 1; i++) held[i] = held[i + 1];
            held[TRAILER_BYTES - 1] = b;
          end
        end
        default: ;
      endcase

      if (bad) begin
        outs[n] = make_res(KIND_ERROR, 8'h00, 32'h0, 32'h0, code);
        n++;
        hdr_phase = PH_HALT;
      end else if (fin) begin
        if (hdr_phase == PH_PAYLOAD && held_count == TRAILER_BYTES) begin
          outs[n] = make_res(KIND_TRAILER, 8'h00, {held[3], held[2], held[1], held[0]},
                             {held[7], held[6], held[5], held[4]}, ERR_MAGIC);
          n++;
          hdr_phase = PH_ID1;
          opt_left = 4'h0;
          skip_count = 16'h0000;
          held_count = 0;
        end else begin
          outs[n] = make_res(KIND_ERROR, 8'h00, 32'h0, 32'h0, ERR_TRUNC);
          n++;
          hdr_phase = PH_HALT;
        end
      end

      if (n > 0) outs[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) results_due.push_back(outs[i]);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put(input logic [7:0] b, input logic fin);
    stim_t s;
    if (cut_at < 0 || byte_idx <= cut_at) begin
      s.data = b;
      s.fin  = fin || (byte_idx == cut_at);
      s.hold = 1'b0;
      member_bytes.push_back(s);
      bytes_planned++;
    end
    byte_idx++;
  endtask

  task automatic put_hold;
    stim_t s;
    s.data = 8'h00;
    s.fin  = 1'b0;
    s.hold = 1'b1;
    member_bytes.push_back(s);
  endtask

  // cut >= 0 marks that byte final and drops the rest of the member
  task automatic add_member(input logic [3:0] opts, input logic ftext, input int xlen,
                            input int name_len, input int cmt_len, input int pay_len,
                            input int cut);
    byte_idx = 0;
    cut_at = cut;
    put(ID1_BYTE, 1'b0);
    put(ID2_BYTE, 1'b0);
    put(CM_DEFLATE, 1'b0);
    put({3'b000, opts, ftext}, 1'b0);
    repeat (6) put(rnd_byte(), 1'b0);
    if (opts[FL_EXTRA]) begin
      put(xlen[7:0], 1'b0);
      put(xlen[15:8], 1'b0);
      repeat (xlen) put(rnd_byte(), 1'b0);
    end
    if (opts[FL_NAME]) begin
      repeat (name_len) put(8'($urandom_range(1, 255)), 1'b0);
      put(8'h00, 1'b0);
    end
    if (opts[FL_COMMENT]) begin
      repeat (cmt_len) put(8'($urandom_range(1, 255)), 1'b0);
      put(8'h00, 1'b0);
    end
    if (opts[FL_HCRC]) repeat (2) put(rnd_byte(), 1'b0);
    for (int i = 0; i < pay_len; i++) put(rnd_byte(), i == pay_len - 1);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : drive
    stim_t nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte, in_final);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (member_bytes.size() != 0 && member_bytes[0].hold) begin
          in_valid <= 1'b0;
          if (results_due.size() == 0) begin
            member_bytes.delete(0);
            drains++;
          end
        end else if (member_bytes.size() != 0) begin
          nxt = member_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.data;
          in_final <= nxt.fin;
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            in_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(20, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d payload %h",
                   $time, kind, payload_byte);
          $display("  crc %h isize %h err %0d last %b",
                   trailer_crc, trailer_isize, error_code, last_of_run);
          failures++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("payload_byte", 32'(want.payload), 32'(payload_byte));
          check_field("trailer_crc", want.crc, trailer_crc);
          check_field("trailer_isize", want.isize, trailer_isize);
          check_field("error_code", 32'(want.err), 32'(error_code));
          check_field("last_of_run", 32'(want.last), 32'(last_of_run));
          case (want.kind)
            KIND_PAYLOAD: seen_payload++;
            KIND_TRAILER: seen_trailer++;
            default:      seen_error++;
          endcase
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          out_hold = pick_gap();
          if ($urandom_range(0, 49) == 0) out_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  initial begin
    ending_e    ending;
    logic [7:0] b;
    logic [3:0] opts;
    int         pay_len;

    // every option, empty extra and name, FTEXT set, one payload beat before the trailer
    add_member(4'b1111, 1'b1, 0, 0, 2, 9, -1);
    // trailer only, no payload beat
    add_member(4'b0000, 1'b0, 0, 0, 0, 8, -1);
    put_hold();

    while (bytes_planned < 430) begin
      opts = 4'($urandom);
      pay_len = 8 + (($urandom_range(0, 5) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(0, 16));
      add_member(opts, 1'($urandom), ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10),
                 $urandom_range(0, 6), $urandom_range(0, 6), pay_len, -1);
      if ($urandom_range(0, 3) == 0) put_hold();
    end

    // a bad byte halts the block for good, so one ending per run
    ending = ending_e'($urandom_range(END_CLEAN, END_SHORT_PAYLOAD));
    byte_idx = 0;
    cut_at = -1;
    case (ending)
      END_BAD_ID1: begin
        do b = 8'($urandom); while (b == ID1_BYTE);
        put(b, 1'($urandom));
      end
      END_BAD_ID2: begin
        put(ID1_BYTE, 1'b0);
        do b = 8'($urandom); while (b == ID2_BYTE);
        put(b, 1'($urandom));
      end
      END_BAD_CM: begin
        put(ID1_BYTE, 1'b0);
        put(ID2_BYTE, 1'b0);
        do b = 8'($urandom); while (b == CM_DEFLATE);
        put(b, 1'($urandom));
      end
      END_RESERVED: begin
        put(ID1_BYTE, 1'b0);
        put(ID2_BYTE, 1'b0);
        put(CM_DEFLATE, 1'b0);
        put({3'($urandom_range(1, 7)), 5'($urandom)}, 1'($urandom));
      end
      END_TRUNC_HDR:
        add_member(4'b1111, 1'($urandom), $urandom_range(2, 5), 1, 1, 9,
                   $urandom_range(0, 11));
      END_SHORT_PAYLOAD:
        add_member(4'($urandom), 1'($urandom), 2, 2, 2, $urandom_range(1, 7), -1);
      default: ;
    endcase
    if (ending != END_CLEAN) begin
      byte_idx = 0;
      cut_at = -1;
      repeat (6) put(rnd_byte(), 1'($urandom));
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != bytes_planned || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d bytes (%0d drain pauses, ending %s): %0d payload beats,",
             bytes_taken, drains, ending.name(), seen_payload);
    $display("  %0d trailer reports and %0d error reports checked", seen_trailer, seen_error);
    if (failures == 0) begin
      $display("** gzip_member_deframer: PASSED **");
    end else begin
      $display("** gzip_member_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d of %0d bytes taken, %0d results outstanding",
             $time, bytes_taken, bytes_planned, results_due.size());
    $display("** gzip_member_deframer: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/gmd_pkg.sv
src/gmd_parser.sv
src/gmd_out_fifo.sv
src/gzip_member_deframer.sv
tb/testbench.sv
